### sv/pnc_pkg.sv
// Shared types and constants for the 2D Perlin noise and curl block.
package pnc_pkg;

  // Entries in the permutation table; all cell and hash indices wrap at this size.
  localparam int unsigned TableSize = 256;
  localparam int unsigned TableAw   = 8;

  localparam int unsigned CoordW = 32;
  localparam int unsigned CfgW   = 24;
  localparam int unsigned ByteW  = 8;

  // The curl offset is 2^-10 in Q16.16.
  localparam int unsigned CurlOffset = 64;

  typedef enum logic [1:0] {
    FuncLoad  = 2'd0,
    FuncNoise = 2'd1,
    FuncCurl  = 2'd2
  } func_e;

  typedef enum logic [0:0] {
    CfgFrequency = 1'b0,
    CfgAmplitude = 1'b1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    OpLoad  = 2'd0,
    OpNoise = 2'd1,
    OpCurl  = 2'd2
  } op_e;

  // Control that travels down the pipeline with every slot.
  typedef struct packed {
    logic       vld;
    op_e        op;
    logic [1:0] sub;
  } tag_t;

endpackage

### sv/perlin_noise_2d_curl_top.sv
// Top level of the pipelined 2D Perlin noise and curl evaluator.
//
// Input items arrive on start_i while busy_o is low. A load item writes one
// permutation table entry and gives no result. A noise item returns one
// result; a curl item issues four noise evaluations on consecutive cycles
// and returns one result built from them. Results appear on value_a_o and
// value_b_o for one cycle with valid_o high; the receiver cannot stall.
// A noise result passes through the pipeline stages and the output register;
// a curl result is built once its fourth sample leaves them. Noise and load
// items can be accepted every cycle while busy_o is low. A curl item keeps
// busy_o high until all four of its samples are issued, because the
// evaluation pipeline takes one sample per cycle.
// The table is held as ten copies with one read port and one write port,
// one copy for each lookup, and a load updates each copy as it passes that
// copy's pipeline stage, which keeps items in flight ordered against table
// writes.
// Frequency and amplitude are written through the cfg port, which is always
// ready. Reset clears the pipeline and sets both registers to 1.0; the
// table content stays undefined until loaded.
module perlin_noise_2d_curl_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  func_i,
  input  logic signed [31:0] x_coord_i,
  input  logic signed [31:0] y_coord_i,
  input  logic [7:0]  table_index_i,
  input  logic [7:0]  table_value_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [0:0]  cfg_index_i,
  input  logic [23:0] cfg_data_i,
  output logic        valid_o,
  output logic signed [31:0] value_a_o,
  output logic signed [31:0] value_b_o
);

  localparam int unsigned Aw = pnc_pkg::TableAw;

  // Configuration registers.
  logic [23:0] freq_q, amp_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      freq_q <= 24'd65536;
      amp_q  <= 24'd65536;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        pnc_pkg::CfgFrequency: freq_q <= cfg_data_i;
        pnc_pkg::CfgAmplitude: amp_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Issue: a curl item replays its point with four offsets.
  logic [1:0]         curl_cnt_q, curl_cnt_d;
  logic signed [31:0] cx_q, cy_q;
  logic               accept;
  logic signed [31:0] base_x, base_y;
  logic signed [32:0] off_x, off_y;
  pnc_pkg::tag_t      tag_in;

  assign busy_o = (curl_cnt_q != 2'd0);
  assign accept = start_i && !busy_o;

  always_comb begin
    tag_in  = '0;
    tag_in.op = pnc_pkg::OpNoise;
    base_x  = x_coord_i;
    base_y  = y_coord_i;
    curl_cnt_d = curl_cnt_q;
    if (busy_o) begin
      base_x     = cx_q;
      base_y     = cy_q;
      tag_in.vld = 1'b1;
      tag_in.op  = pnc_pkg::OpCurl;
      tag_in.sub = curl_cnt_q;
      curl_cnt_d = curl_cnt_q + 2'd1;
    end else if (accept) begin
      unique case (func_i)
        pnc_pkg::FuncLoad: begin
          tag_in.vld = 1'b1;
          tag_in.op  = pnc_pkg::OpLoad;
        end
        pnc_pkg::FuncNoise: begin
          tag_in.vld = 1'b1;
          tag_in.op  = pnc_pkg::OpNoise;
        end
        pnc_pkg::FuncCurl: begin
          tag_in.vld = 1'b1;
          tag_in.op  = pnc_pkg::OpCurl;
          curl_cnt_d = 2'd1;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    off_x = 33'(base_x);
    off_y = 33'(base_y);
    if (tag_in.op == pnc_pkg::OpCurl) begin
      case (tag_in.sub)
        2'd0: off_x = 33'(base_x) + 33'(pnc_pkg::CurlOffset);
        2'd1: off_x = 33'(base_x) - 33'(pnc_pkg::CurlOffset);
        2'd2: off_y = 33'(base_y) + 33'(pnc_pkg::CurlOffset);
        default: off_y = 33'(base_y) - 33'(pnc_pkg::CurlOffset);
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      curl_cnt_q <= 2'd0;
    end else begin
      curl_cnt_q <= curl_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && !busy_o) begin
      cx_q <= x_coord_i;
      cy_q <= y_coord_i;
    end
  end

  // Pipeline tags.
  pnc_pkg::tag_t t1_q, t2_q, t3_q, t4_q, t5_q, t6_q, t7_q, t8_q, t9_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t1_q <= '0; t2_q <= '0; t3_q <= '0; t4_q <= '0; t5_q <= '0;
      t6_q <= '0; t7_q <= '0; t8_q <= '0; t9_q <= '0;
    end else begin
      t1_q <= tag_in; t2_q <= t1_q; t3_q <= t2_q; t4_q <= t3_q; t5_q <= t4_q;
      t6_q <= t5_q;   t7_q <= t6_q; t8_q <= t7_q; t9_q <= t8_q;
    end
  end

  // Load payload travels to the last table group.
  logic [7:0] idx1_q, idx2_q, idx3_q, idx4_q;
  logic [7:0] val1_q, val2_q, val3_q, val4_q;

  always_ff @(posedge clk_i) begin
    idx1_q <= table_index_i; val1_q <= table_value_i;
    idx2_q <= idx1_q;        val2_q <= val1_q;
    idx3_q <= idx2_q;        val3_q <= val2_q;
    idx4_q <= idx3_q;        val4_q <= val3_q;
  end

  logic we1, we2, we3;
  assign we1 = t2_q.vld && (t2_q.op == pnc_pkg::OpLoad);
  assign we2 = t3_q.vld && (t3_q.op == pnc_pkg::OpLoad);
  assign we3 = t4_q.vld && (t4_q.op == pnc_pkg::OpLoad);

  // Stage 1: offset point.
  logic signed [32:0] xq1_q, yq1_q;
  always_ff @(posedge clk_i) begin
    xq1_q <= off_x;
    yq1_q <= off_y;
  end

  // Stage 2: scale by frequency.
  logic signed [57:0] prod_x, prod_y;
  logic signed [41:0] px2_q, py2_q;
  assign prod_x = xq1_q * $signed({1'b0, freq_q});
  assign prod_y = yq1_q * $signed({1'b0, freq_q});
  always_ff @(posedge clk_i) begin
    px2_q <= prod_x[57:16];
    py2_q <= prod_y[57:16];
  end

  logic [15:0] fx2, fy2;
  logic [Aw-1:0] ix2, iy2;
  assign fx2 = px2_q[15:0];
  assign fy2 = py2_q[15:0];
  assign ix2 = px2_q[16+Aw-1:16];
  assign iy2 = py2_q[16+Aw-1:16];

  // Table group 1: perm[ix] and perm[ix+1].
  logic [7:0] g1_mem [2][pnc_pkg::TableSize];
  logic [7:0] g1_rd_q [2];
  logic [Aw-1:0] g1_addr [2];
  assign g1_addr[0] = ix2;
  assign g1_addr[1] = ix2 + Aw'(1);

  for (genvar c = 0; c < 2; c++) begin : gen_g1
    always_ff @(posedge clk_i) begin
      if (we1) begin
        g1_mem[c][idx2_q[Aw-1:0]] <= val2_q;
      end
      g1_rd_q[c] <= g1_mem[c][g1_addr[c]];
    end
  end

  // Stage 3: fractions, cell rows, squares.
  logic [15:0] fx3_q, fy3_q;
  logic [Aw-1:0] iy3_q;
  logic [31:0] t2x3_q, t2y3_q;
  always_ff @(posedge clk_i) begin
    fx3_q  <= fx2;
    fy3_q  <= fy2;
    iy3_q  <= iy2;
    t2x3_q <= fx2 * fx2;
    t2y3_q <= fy2 * fy2;
  end

  // Table group 2: perm[a], perm[a+1], perm[b], perm[b+1].
  logic [Aw-1:0] a3, b3;
  assign a3 = g1_rd_q[0][Aw-1:0] + iy3_q;
  assign b3 = g1_rd_q[1][Aw-1:0] + iy3_q;

  logic [7:0] g2_mem [4][pnc_pkg::TableSize];
  logic [7:0] g2_rd_q [4];
  logic [Aw-1:0] g2_addr [4];
  assign g2_addr[0] = a3;
  assign g2_addr[1] = a3 + Aw'(1);
  assign g2_addr[2] = b3;
  assign g2_addr[3] = b3 + Aw'(1);

  for (genvar c = 0; c < 4; c++) begin : gen_g2
    always_ff @(posedge clk_i) begin
      if (we2) begin
        g2_mem[c][idx3_q[Aw-1:0]] <= val3_q;
      end
      g2_rd_q[c] <= g2_mem[c][g2_addr[c]];
    end
  end

  // Stage 4: fade cube and polynomial.
  logic [47:0] cube_x, cube_y;
  logic [36:0] polyf_x, polyf_y;
  logic [15:0] fx4_q, fy4_q, t3x4_q, t3y4_q;
  logic [20:0] polx4_q, poly4_q;

  assign cube_x  = t2x3_q * fx3_q;
  assign cube_y  = t2y3_q * fy3_q;
  assign polyf_x = 37'd6 * 37'(t2x3_q) + (37'd10 << 32) - ((37'd15 * 37'(fx3_q)) << 16);
  assign polyf_y = 37'd6 * 37'(t2y3_q) + (37'd10 << 32) - ((37'd15 * 37'(fy3_q)) << 16);

  always_ff @(posedge clk_i) begin
    fx4_q   <= fx3_q;
    fy4_q   <= fy3_q;
    t3x4_q  <= cube_x[47:32];
    t3y4_q  <= cube_y[47:32];
    polx4_q <= polyf_x[36:16];
    poly4_q <= polyf_y[36:16];
  end

  // Table group 3: final corner hashes in the order 00, 10, 01, 11.
  logic [7:0] g3_mem [4][pnc_pkg::TableSize];
  logic [7:0] g3_rd_q [4];
  logic [Aw-1:0] g3_addr [4];
  assign g3_addr[0] = g2_rd_q[0][Aw-1:0];
  assign g3_addr[1] = g2_rd_q[2][Aw-1:0];
  assign g3_addr[2] = g2_rd_q[1][Aw-1:0];
  assign g3_addr[3] = g2_rd_q[3][Aw-1:0];

  for (genvar c = 0; c < 4; c++) begin : gen_g3
    always_ff @(posedge clk_i) begin
      if (we3) begin
        g3_mem[c][idx4_q[Aw-1:0]] <= val4_q;
      end
      g3_rd_q[c] <= g3_mem[c][g3_addr[c]];
    end
  end

  // Stage 5: fade result.
  logic [36:0] fade_x, fade_y;
  logic [15:0] fx5_q, fy5_q;
  logic [16:0] u5_q, v5_q;
  assign fade_x = t3x4_q * polx4_q;
  assign fade_y = t3y4_q * poly4_q;
  always_ff @(posedge clk_i) begin
    fx5_q <= fx4_q;
    fy5_q <= fy4_q;
    u5_q  <= fade_x[32:16];
    v5_q  <= fade_y[32:16];
  end

  // Stage 6: corner gradients.
  function automatic logic signed [18:0] grad(input logic [7:0] hash,
                                              input logic signed [17:0] gx,
                                              input logic signed [17:0] gy);
    logic [3:0]         h;
    logic signed [18:0] gu, gv;
    h  = hash[3:0];
    gu = (h < 4'd8) ? 19'(gx) : 19'(gy);
    if (h < 4'd4) begin
      gv = 19'(gy);
    end else if (h == 4'd12 || h == 4'd14) begin
      gv = 19'(gx);
    end else begin
      gv = '0;
    end
    if (h[0]) gu = -gu;
    if (h[1]) gv = -gv;
    return gu + gv;
  endfunction

  logic signed [17:0] x0, x1, y0, y1;
  assign x0 = $signed({2'b00, fx5_q});
  assign x1 = $signed({2'b11, fx5_q});
  assign y0 = $signed({2'b00, fy5_q});
  assign y1 = $signed({2'b11, fy5_q});

  logic signed [18:0] g00_q, g10_q, g01_q, g11_q;
  logic [16:0] u6_q, v6_q;
  always_ff @(posedge clk_i) begin
    g00_q <= grad(g3_rd_q[0], x0, y0);
    g10_q <= grad(g3_rd_q[1], x1, y0);
    g01_q <= grad(g3_rd_q[2], x0, y1);
    g11_q <= grad(g3_rd_q[3], x1, y1);
    u6_q  <= u5_q;
    v6_q  <= v5_q;
  end

  // Stage 7: blend along x.
  logic signed [19:0] d0, d1;
  logic signed [37:0] m0, m1;
  logic signed [20:0] l0_q, l1_q;
  logic [16:0] v7_q;
  assign d0 = 20'(g10_q) - 20'(g00_q);
  assign d1 = 20'(g11_q) - 20'(g01_q);
  assign m0 = $signed({1'b0, u6_q}) * d0;
  assign m1 = $signed({1'b0, u6_q}) * d1;
  always_ff @(posedge clk_i) begin
    l0_q <= 21'(g00_q) + 21'(m0 >>> 16);
    l1_q <= 21'(g01_q) + 21'(m1 >>> 16);
    v7_q <= v6_q;
  end

  // Stage 8: blend along y.
  logic signed [21:0] dy;
  logic signed [39:0] my;
  logic signed [23:0] res8_q;
  assign dy = 22'(l1_q) - 22'(l0_q);
  assign my = $signed({1'b0, v7_q}) * dy;
  always_ff @(posedge clk_i) begin
    res8_q <= 24'(l0_q) + 24'(my >>> 16);
  end

  // Stage 9: amplitude map. The result stays well inside 32 bits.
  logic signed [24:0] res_p1;
  logic signed [49:0] scaled;
  logic signed [31:0] n9_q;
  assign res_p1 = 25'(res8_q) + 25'sd65536;
  assign scaled = res_p1 * $signed({1'b0, amp_q});
  always_ff @(posedge clk_i) begin
    n9_q <= scaled[48:17];
  end

  // Curl assembly and output register.
  function automatic logic signed [31:0] sat_x512(input logic signed [32:0] d);
    logic signed [41:0] s;
    s = {d, 9'd0};
    if (s > 42'sh0007FFFFFFF) begin
      return 32'sh7FFFFFFF;
    end else if (s < -42'sh00080000000) begin
      return 32'sh80000000;
    end else begin
      return s[31:0];
    end
  endfunction

  logic signed [31:0] hold_q;
  logic signed [32:0] ndx_q, ndy;
  logic               out_vld_q;
  logic signed [31:0] out_a_q, out_b_q;

  assign ndy = 33'(hold_q) - 33'(n9_q);

  always_ff @(posedge clk_i) begin
    if (t9_q.vld && t9_q.op == pnc_pkg::OpCurl) begin
      case (t9_q.sub)
        2'd0, 2'd2: hold_q <= n9_q;
        2'd1:       ndx_q  <= 33'(hold_q) - 33'(n9_q);
        default:    ;
      endcase
    end
    if (t9_q.vld && t9_q.op == pnc_pkg::OpNoise) begin
      out_a_q <= n9_q;
      out_b_q <= '0;
    end else begin
      out_a_q <= sat_x512(-ndy);
      out_b_q <= sat_x512(ndx_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= t9_q.vld && ((t9_q.op == pnc_pkg::OpNoise) ||
                   (t9_q.op == pnc_pkg::OpCurl && t9_q.sub == 2'd3));
    end
  end

  assign valid_o   = out_vld_q;
  assign value_a_o = out_a_q;
  assign value_b_o = out_b_q;

endmodule
